// ===== sv/matrix_rotate_90_clockwise_unit_macros.svh =====
// Assertion macros used by the checker file of the matrix rotate unit.
`ifndef MATRIX_ROTATE_90_CLOCKWISE_UNIT_MACROS_SVH
`define MATRIX_ROTATE_90_CLOCKWISE_UNIT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MR90_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every clock edge, reset cycles included.
`define MR90_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/mr90_pkg.sv =====
// Package: shared constants, types and helpers of the matrix rotate unit.
`default_nettype none
package mr90_pkg;

  localparam int MAX_N     = 8;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int IDX_W     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CELL_W    = 2 * IDX_W;
  localparam int ADDR_W    = CELL_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(4);

  // Frame handed from loader to reader: buffer bank and side length minus one.
  typedef struct packed {
    logic             bank;
    logic [IDX_W-1:0] n_m1;
  } frame_desc_t;

  // Reader tells loader that a bank has been fully read.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  // Clamp the size register to 1..MAX_N and return side length minus one.
  function automatic logic [IDX_W-1:0] side_m1(input logic [CFG_W-1:0] sz);
    logic [IDX_W-1:0] res;
    if (sz == '0) begin
      res = '0;
    end else if (sz > CFG_W'(MAX_N)) begin
      res = IDX_W'(MAX_N - 1);
    end else begin
      res = IDX_W'(sz - CFG_W'(1));
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mr90_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mr90_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== sv/mr90_front.sv =====
// Loader: accepts elements, writes them into a free bank, hands off full frames.
`default_nettype none
module mr90_front import mr90_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_wr_data,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [DATA_W-1:0]   in_element_value,
  input  wire bank_release_t       release_i,
  input  wire logic                q_full,
  output      logic                q_push,
  output      frame_desc_t         q_desc,
  output      ram_wr_t             ram_wr
);

  logic [CFG_W-1:0]  size_r, size_nxt;
  logic [CELL_W-1:0] cnt_r, cnt_nxt;
  logic              load_bank_r, load_bank_nxt;
  logic [1:0]        busy_r, busy_nxt;

  logic [IDX_W-1:0]  n_m1;
  logic [IDX_W:0]    side;
  logic [CELL_W:0]   total;
  logic              accept;
  logic              frame_done;

  assign n_m1       = side_m1(size_r);
  assign side       = {1'b0, n_m1} + (IDX_W+1)'(1);
  assign total      = (CELL_W+1)'(side) * (CELL_W+1)'(side);
  assign frame_done = (({1'b0, cnt_r} + (CELL_W+1)'(1)) == total);

  assign in_stall = busy_r[load_bank_r] | q_full;
  assign accept   = in_valid & ~in_stall;

  assign ram_wr.en   = accept;
  assign ram_wr.addr = {load_bank_r, cnt_r};
  assign ram_wr.data = in_element_value;

  assign q_push      = accept & frame_done;
  assign q_desc.bank = load_bank_r;
  assign q_desc.n_m1 = n_m1;

  always_comb begin
    size_nxt      = size_r;
    cnt_nxt       = cnt_r;
    load_bank_nxt = load_bank_r;
    busy_nxt      = busy_r;
    if (release_i.valid) begin
      busy_nxt[release_i.bank] = 1'b0;
    end
    if (accept) begin
      if (frame_done) begin
        cnt_nxt                = '0;
        busy_nxt[load_bank_r]  = 1'b1;
        load_bank_nxt          = ~load_bank_r;
      end else begin
        cnt_nxt = cnt_r + CELL_W'(1);
      end
    end
    if (cfg_wr_en) begin
      size_nxt = cfg_wr_data;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      cnt_r       <= '0;
      load_bank_r <= 1'b0;
      busy_r      <= '0;
    end else begin
      size_r      <= size_nxt;
      cnt_r       <= cnt_nxt;
      load_bank_r <= load_bank_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mr90_queue.sv =====
// Two-entry queue of frame descriptors between loader and reader.
`default_nettype none
module mr90_queue import mr90_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire frame_desc_t push_desc,
  input  wire logic        pop,
  output      logic        full,
  output      logic        not_empty,
  output      frame_desc_t head
);

  frame_desc_t entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mr90_back.sv =====
// Reader: walks a stored frame in rotated order and streams it out.
`default_nettype none
module mr90_back import mr90_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_not_empty,
  input  wire frame_desc_t       q_head,
  output      logic              q_pop,
  output      logic              rd_en,
  output      logic [ADDR_W-1:0] rd_addr,
  input  wire logic [DATA_W-1:0] rd_data,
  output      bank_release_t     release_o,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [DATA_W-1:0] out_rotated_value,
  output      logic              out_last_of_frame
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } back_state_t;

  localparam int PROD_W = CELL_W + 1;

  back_state_t      state_r, state_nxt;
  frame_desc_t      desc_r, desc_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic             pend_r;
  logic             pend_last_r;

  // Output skid queue, two beats deep.
  logic [DATA_W-1:0] oval_r  [2];
  logic              olast_r [2];
  logic              owr_r, ord_r;
  logic [1:0]        ocnt_r;

  logic              out_pop;
  logic              can_issue;
  logic              issue;
  logic              is_last;
  logic [IDX_W-1:0]  rev_col;
  logic [PROD_W-1:0] prod;
  logic [CELL_W-1:0] src;

  assign out_valid         = (ocnt_r != 2'd0);
  assign out_rotated_value = oval_r[ord_r];
  assign out_last_of_frame = olast_r[ord_r];
  assign out_pop           = out_valid & ~out_stall;

  // Leave room for the read in flight and the one issued now.
  assign can_issue = ((3'(ocnt_r) + 3'(pend_r) - 3'(out_pop)) < 3'd2);
  assign issue     = (state_r == ST_READ) & can_issue;

  // Rotated (row, col) reads source cell (n-1-col, row).
  assign rev_col = desc_r.n_m1 - col_r;
  assign prod    = PROD_W'(rev_col) * (PROD_W'(desc_r.n_m1) + PROD_W'(1));
  assign src     = prod[CELL_W-1:0] + CELL_W'(row_r);
  assign is_last = (row_r == desc_r.n_m1) & (col_r == desc_r.n_m1);

  assign rd_en   = issue;
  assign rd_addr = {desc_r.bank, src};

  assign release_o.valid = issue & is_last;
  assign release_o.bank  = desc_r.bank;

  assign q_pop = (state_r == ST_IDLE) & q_not_empty;

  always_comb begin
    state_nxt = state_r;
    desc_nxt  = desc_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          desc_nxt  = q_head;
          row_nxt   = '0;
          col_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (issue) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else if (col_r == desc_r.n_m1) begin
            col_nxt = '0;
            row_nxt = row_r + IDX_W'(1);
          end else begin
            col_nxt = col_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    desc_r      <= desc_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    pend_last_r <= issue ? is_last : pend_last_r;
    if (pend_r) begin
      oval_r[owr_r]  <= rd_data;
      olast_r[owr_r] <= pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      owr_r   <= 1'b0;
      ord_r   <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      owr_r   <= pend_r ? ~owr_r : owr_r;
      ord_r   <= out_pop ? ~ord_r : ord_r;
      ocnt_r  <= ocnt_r + 2'(pend_r) - 2'(out_pop);
    end
  end

endmodule
`default_nettype wire

// ===== sv/matrix_rotate_90_clockwise_unit.sv =====
// Top level: N by N matrix rotation by 90 degrees clockwise, streaming.
//
//   channel  dir  handshake           payload
//   cfg      in   cfg_wr_en           cfg_wr_data (matrix size N, 4 bits)
//   in       in   in_valid/in_stall   in_element_value (row-major element)
//   out      out  out_valid/out_stall out_rotated_value, out_last_of_frame
//
// Load one beat per cycle while in_stall is low, into the free one of two RAM banks;
// loading overlaps readout. The first rotated beat is offered after the descriptor queue,
// reader pickup and registered RAM read into the two-beat output queue.
// Readout sends N*N beats at one per cycle while out_stall is low, and the reader
// passes through its idle state between frames.
// With both banks waiting for readout, in_stall holds until a bank is fully read; the
// buffer needs no clearing pass after reset.
`default_nettype none
module matrix_rotate_90_clockwise_unit import mr90_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic signed [DATA_W-1:0] in_element_value,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic signed [DATA_W-1:0] out_rotated_value,
  output      logic              out_last_of_frame
);

  // Loader to queue
  logic          q_push;
  frame_desc_t   q_push_desc;
  logic          q_full;

  // Queue to reader
  logic          q_pop;
  logic          q_not_empty;
  frame_desc_t   q_head;

  // Reader back to loader: free a bank once its last cell is read
  bank_release_t bank_release;

  // Buffer RAM ports
  ram_wr_t           ram_wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] out_value;

  mr90_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .release_i        (bank_release),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_desc           (q_push_desc),
    .ram_wr           (ram_wr)
  );

  mr90_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Two banks of MAX_N*MAX_N words: bank select is the top address bit.
  mr90_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mr90_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .release_o         (bank_release),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rotated_value (out_value),
    .out_last_of_frame (out_last_of_frame)
  );

  assign out_rotated_value = signed'(out_value);

endmodule
`default_nettype wire

// ===== sv/mr90_checker.sv =====
// Checker: port-level assertions on the matrix rotate unit, bound to the top.
`default_nettype none
`include "matrix_rotate_90_clockwise_unit_macros.svh"
module mr90_checker import mr90_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [DATA_W-1:0] out_rotated_value,
  input wire logic              out_last_of_frame
);

  logic            out_held;
  logic [DATA_W:0] out_beat;

  assign out_held = out_valid & out_stall;
  assign out_beat = {out_rotated_value, out_last_of_frame};

  // A stalled result beat stays offered.
  `MR90_ASSERT(a_out_hold, out_held |=> out_valid, "out beat dropped while stalled")

  // A stalled result beat keeps its payload.
  `MR90_ASSERT(a_out_stable, out_held |=> $stable(out_beat), "out payload changed while stalled")

  // Reset leaves no result beat pending.
  `MR90_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "out_valid after reset")

  // Reset frees both banks, so loading may start at once.
  `MR90_ASSERT_ALWAYS(a_rst_in, !rst_n |=> !in_stall, "in_stall after reset")

endmodule

bind matrix_rotate_90_clockwise_unit mr90_checker u_mr90_checker (.*);
`default_nettype wire

// ===== tb/matrix_rotate_90_clockwise_unit_test.sv =====
// Testbench for the matrix rotate unit: own rotation predictor and a checker that compares every beat.
`default_nettype none
module matrix_rotate_90_clockwise_unit_test;
  import mr90_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run bounds.
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 420;
  localparam int SETTLE_CYCLES = 16;    // well past the readout start
  localparam int LONG_HOLD     = 300;   // one long receiver hold-off
  localparam int HOLD_BACKLOG  = 40;    // pending items needed to trigger it
  localparam int BUF_ENTRIES   = MAX_N * MAX_N;

  // One beat of the rotated matrix as the checker expects it.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } rotated_beat_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]         cfg_wr_data = SIZE_RESET;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_rotated_value;
  logic                     out_last_of_frame;

  matrix_rotate_90_clockwise_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rotated_value(out_rotated_value),
    .out_last_of_frame(out_last_of_frame)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Rotation predictor: a private copy of the size register, the load count
  // and the frame store. Each accepted element goes in here; a completed frame
  // appends its N*N rotated beats to the expectation queue.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  size_reg = SIZE_RESET;
  int                loaded_count = 0;
  logic [DATA_W-1:0] frame_store [BUF_ENTRIES];
  rotated_beat_t     rotated_expected [$];

  // Size zero means one, anything above the buffer limit means the limit.
  function automatic int effective_side(input logic [CFG_W-1:0] sz);
    if (sz == '0) return 1;
    if (int'(sz) > MAX_N) return MAX_N;
    return int'(sz);
  endfunction

  function automatic void predict_rotation(input logic [DATA_W-1:0] elem);
    int            n;
    int            total;
    rotated_beat_t beat;
    n     = effective_side(size_reg);
    total = n * n;
    if (loaded_count >= total) loaded_count = 0;
    if (loaded_count < BUF_ENTRIES) frame_store[loaded_count] = elem;
    loaded_count = (loaded_count + 1) & 127;
    if (loaded_count < total) return;
    // Output (i,j) comes from input (N-1-j, i).
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        beat.value = frame_store[(n - 1 - j) * n + i];
        beat.last  = (i == n - 1) && (j == n - 1);
        rotated_expected.push_back(beat);
      end
    end
    loaded_count = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: drain the pending element queue in bursts of random length with
  // random gaps. Hold valid and payload while the block stalls.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] pending_elements [$];
  int                elements_queued = 0;
  int                elements_taken = 0;
  int                burst_left = 0;
  int                gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Record the beat the block took at this edge.
      if (in_valid && !in_stall) begin
        predict_rotation(in_element_value);
        elements_taken++;
      end
      // A stalled beat stays put; otherwise pick the next one or idle.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_elements.size() > 0) begin
          in_valid         <= 1'b1;
          in_element_value <= pending_elements.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // New burst; every so often no gap at all for long streams.
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 2);
              2:       gap_left = $urandom_range(1, 7);
              default: gap_left = $urandom_range(8, 24);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern that changes from epoch to epoch. Once, while
  // the driver still has a large backlog, hold off for a long stretch so both
  // banks fill and the block stalls its input.
  // ---------------------------------------------------------------------------
  int       long_hold_left = 0;
  bit       long_hold_done = 1'b0;
  int       epoch_left = 0;
  int       stall_mode = 0;
  bit [7:0] stall_pattern = 8'b1100_1010;

  always @(posedge clk) begin
    if (long_hold_left > 0) begin
      long_hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && pending_elements.size() >= HOLD_BACKLOG) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (epoch_left == 0) begin
        stall_mode    = $urandom_range(0, 3);
        epoch_left    = $urandom_range(20, 80);
        stall_pattern = 8'($urandom());
      end else begin
        epoch_left--;
      end
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 25);
        2:       out_stall <= stall_pattern[0];
        default: out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted result beat with the oldest expectation.
  // ---------------------------------------------------------------------------
  int            mismatches = 0;
  rotated_beat_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: value %h last %b", out_rotated_value,
                   out_last_of_frame);
      end else begin
        want = rotated_expected.pop_front();
        if (out_rotated_value !== want.value || out_last_of_frame !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected value %h last %b, got value %h last %b",
                     want.value, want.last, out_rotated_value, out_last_of_frame);
        end
      end
    end
  end

  // Watchdog.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("matrix_rotate_90_clockwise_unit_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------
  localparam logic [DATA_W-1:0] CORNER_VALUES [8] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h8000_0001
  };

  task automatic queue_element(input logic [DATA_W-1:0] v);
    pending_elements.push_back(v);
    elements_queued++;
  endtask

  function automatic logic [DATA_W-1:0] random_element();
    if ($urandom_range(0, 99) < 15) return CORNER_VALUES[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Block until every element is taken and every rotated beat has arrived,
  // then let the pipeline settle for partly loaded frames.
  task automatic wait_quiet();
    while (elements_taken != elements_queued || rotated_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write matrix_size; the write also drops any partly loaded frame.
  task automatic write_matrix_size(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    size_reg     = v;
    loaded_count = 0;
    cfg_wr_en   <= 1'b0;
  endtask

  // Forced sizes at the start of the random part; the first one feeds the
  // long hold-off with a deep backlog.
  localparam logic [CFG_W-1:0] OPENING_SIZES [11] = '{
    4'd3, 4'd15, 4'd8, 4'd9, 4'd1, 4'd5, 4'd6, 4'd7, 4'd2, 4'd4, 4'd0
  };

  initial begin
    int               random_count;
    int               phase;
    int               frames;
    int               side;
    logic [CFG_W-1:0] sz;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: one frame at the reset size, corners first, then markers so a
    // wrong source index shows up.
    for (int k = 0; k < 16; k++)
      queue_element(k < 8 ? CORNER_VALUES[k] : 32'h0101_0101 * k);
    wait_quiet();

    // Directed: size zero acts as one, so each element is its own frame.
    write_matrix_size(4'd0);
    queue_element(32'h8000_0000);
    queue_element(32'h7FFF_FFFF);
    wait_quiet();

    // Directed: a size write mid-frame drops the partial frame.
    write_matrix_size(4'd2);
    for (int k = 0; k < 3; k++) queue_element(32'hDEAD_0000 + k);
    wait_quiet();
    write_matrix_size(4'd2);
    for (int k = 0; k < 4; k++) queue_element(32'h0BAD_0000 + k);
    wait_quiet();

    // Random: well-formed frames with random content, now and then a
    // truncated frame that the next size write throws away.
    random_count = 0;
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      if (phase < 11) begin
        sz = OPENING_SIZES[phase];
      end else if ($urandom_range(0, 99) < 75) begin
        sz = CFG_W'($urandom_range(0, 4));
      end else begin
        sz = CFG_W'($urandom_range(0, 15));
      end
      write_matrix_size(sz);
      side = effective_side(sz);
      if (phase == 0) frames = 10;
      else if (side >= 6) frames = 1;
      else frames = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) begin
        for (int k = 0; k < side * side; k++) begin
          queue_element(random_element());
          random_count++;
        end
      end
      if (side > 1 && $urandom_range(0, 99) < 25) begin
        frames = $urandom_range(1, side * side - 1);
        for (int k = 0; k < frames; k++) begin
          queue_element(random_element());
          random_count++;
        end
      end
      wait_quiet();
      phase++;
    end

    // Drain and let the block fall silent before judging.
    wait_quiet();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && rotated_expected.size() == 0) begin
      $display("matrix_rotate_90_clockwise_unit_test: PASS");
    end else begin
      $display("matrix_rotate_90_clockwise_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
